/* sv/dncs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dncs_pkg
// Shared types and constants of the debounced nearest candidate selector.
// ----------------------------------------------------------------------------
package dncs_pkg;

    localparam int ID_W     = 8;
    localparam int DIST_W   = 20;
    localparam int DISTX_W  = DIST_W + 1;
    localparam int CNT_W    = 8;
    localparam int MARGIN_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFGIDX_W = 2;

    // infinite distance sits above every finite one
    localparam logic [DISTX_W-1:0] DIST_INF = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX  = '1;

    // item commands
    localparam logic [1:0] CMD_CAND   = 2'd0;
    localparam logic [1:0] CMD_EMPTY  = 2'd1;
    localparam logic [1:0] CMD_MANUAL = 2'd2;

    // configuration register indexes
    localparam logic [CFGIDX_W-1:0] CFG_CONFIRM = 2'd0;
    localparam logic [CFGIDX_W-1:0] CFG_MARGIN  = 2'd1;
    localparam logic [CFGIDX_W-1:0] CFG_START   = 2'd2;

    // reset values of the configuration registers
    localparam logic [CNT_W-1:0]    CONFIRM_RST = 8'd1;
    localparam logic [MARGIN_W-1:0] MARGIN_RST  = 16'd0;
    localparam logic [ID_W-1:0]     START_RST   = 8'd1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ID_W-1:0]   cand_id;
        logic [DIST_W-1:0] distance_dm;
        logic              distance_infinite;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]  selected_id;
        logic [CNT_W-1:0] pending_count;
    } result_t;

    // configuration write bundle
    typedef struct packed {
        logic                wr_en;
        logic [CFGIDX_W-1:0] index;
        logic [CFG_W-1:0]    wdata;
    } cfg_wr_t;

    function automatic logic [ID_W-1:0] at_least_one(input logic [ID_W-1:0] v);
        return (v == '0) ? ID_W'(1) : v;
    endfunction

endpackage

/* sv/dncs_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dncs_in_stage
// Input register: holds one item until the selection core takes it.
// ----------------------------------------------------------------------------
module dncs_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dncs_pkg::item_t s_item,
    output logic           item_valid,
    output dncs_pkg::item_t item,
    input  logic           item_done
);
    import dncs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // free when empty or when the held item leaves this cycle
    assign s_ready    = !valid_reg || item_done;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (item_done ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* sv/dncs_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dncs_core: round tracking, switch decision and confirmation counting.
// One item a cycle, but an item with a result waits while the output slot is full.
// ----------------------------------------------------------------------------
module dncs_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  dncs_pkg::cfg_wr_t cfg,
    input  logic             item_valid,
    input  dncs_pkg::item_t  item,
    input  logic             out_free,
    output logic             item_done,
    output logic             res_valid,
    output dncs_pkg::result_t res
);
    import dncs_pkg::*;

    // configuration
    logic [CNT_W-1:0]    confirm_reg;
    logic [MARGIN_W-1:0] margin_reg;

    // selection and round state
    logic [ID_W-1:0]    current_sel_reg, current_sel_next;
    logic [ID_W-1:0]    pending_sel_reg, pending_sel_next;
    logic               pending_valid_reg, pending_valid_next;
    logic [CNT_W-1:0]   pending_cnt_reg, pending_cnt_next;
    logic [ID_W-1:0]    best_sel_reg, best_sel_next;
    logic [DISTX_W-1:0] best_dist_reg, best_dist_next;
    logic               round_open_reg, round_open_next;
    logic [DISTX_W-1:0] cur_dist_reg, cur_dist_next;
    logic               cur_found_reg, cur_found_next;

    logic               wants_result;
    logic [DISTX_W-1:0] d;
    logic [ID_W-1:0]    nb_sel;
    logic [DISTX_W-1:0] nb_dist;
    logic               nc_found;
    logic [DISTX_W-1:0] nc_dist;
    logic [DISTX_W:0]   challenge_sum;
    logic               no_switch;
    logic [CNT_W-1:0]   cnt_upd;
    logic [ID_W-1:0]    psel_upd;

    // an item moves on unless it has a result and the output slot is full
    always_comb begin
        case (item.cmd)
            CMD_CAND:   wants_result = item.last;
            CMD_EMPTY:  wants_result = 1'b1;
            CMD_MANUAL: wants_result = 1'b1;
            default:    wants_result = 1'b0;
        endcase
    end

    assign item_done = item_valid && (!wants_result || out_free);
    assign res_valid = item_done && wants_result;

    // nearest candidate and current selection's distance, this item included
    always_comb begin
        d        = item.distance_infinite ? DIST_INF : {1'b0, item.distance_dm};
        nb_sel   = best_sel_reg;
        nb_dist  = best_dist_reg;
        nc_found = cur_found_reg;
        nc_dist  = cur_dist_reg;
        if (!round_open_reg || d < best_dist_reg) begin
            nb_sel  = item.cand_id;
            nb_dist = d;
        end
        if (!cur_found_reg && item.cand_id == current_sel_reg) begin
            nc_found = 1'b1;
            nc_dist  = d;
        end
    end

    // challenger must beat the current distance by more than the margin
    assign challenge_sum = {1'b0, nb_dist} + {{(DISTX_W + 1 - MARGIN_W){1'b0}}, margin_reg};
    assign no_switch = (nb_dist == DIST_INF) || (nb_sel == current_sel_reg) ||
                       (nc_found && nc_dist != DIST_INF &&
                        challenge_sum >= {1'b0, nc_dist});

    // confirmation count for the proposal
    always_comb begin
        psel_upd = nb_sel;
        if (!pending_valid_reg || pending_sel_reg != nb_sel) begin
            cnt_upd = CNT_W'(1);
        end else if (pending_cnt_reg != CNT_MAX) begin
            cnt_upd = pending_cnt_reg + CNT_W'(1);
        end else begin
            cnt_upd = pending_cnt_reg;
        end
    end

    // next state
    always_comb begin
        current_sel_next   = current_sel_reg;
        pending_sel_next   = pending_sel_reg;
        pending_valid_next = pending_valid_reg;
        pending_cnt_next   = pending_cnt_reg;
        best_sel_next      = best_sel_reg;
        best_dist_next     = best_dist_reg;
        round_open_next    = round_open_reg;
        cur_dist_next      = cur_dist_reg;
        cur_found_next     = cur_found_reg;
        if (item_done) begin
            case (item.cmd)
                CMD_CAND: begin
                    if (!item.last) begin
                        round_open_next = 1'b1;
                        best_sel_next   = nb_sel;
                        best_dist_next  = nb_dist;
                        cur_found_next  = nc_found;
                        cur_dist_next   = nc_dist;
                    end else begin
                        round_open_next = 1'b0;
                        best_sel_next   = '0;
                        best_dist_next  = DIST_INF;
                        cur_found_next  = 1'b0;
                        cur_dist_next   = DIST_INF;
                        if (no_switch || cnt_upd >= at_least_one(confirm_reg)) begin
                            pending_valid_next = 1'b0;
                            pending_sel_next   = '0;
                            pending_cnt_next   = '0;
                            if (!no_switch) begin
                                current_sel_next = psel_upd;
                            end
                        end else begin
                            pending_valid_next = 1'b1;
                            pending_sel_next   = psel_upd;
                            pending_cnt_next   = cnt_upd;
                        end
                    end
                end
                CMD_EMPTY, CMD_MANUAL: begin
                    if (item.cmd == CMD_MANUAL) begin
                        current_sel_next = at_least_one(item.cand_id);
                    end
                    pending_valid_next = 1'b0;
                    pending_sel_next   = '0;
                    pending_cnt_next   = '0;
                    round_open_next    = 1'b0;
                    best_sel_next      = '0;
                    best_dist_next     = DIST_INF;
                    cur_found_next     = 1'b0;
                    cur_dist_next      = DIST_INF;
                end
                default: begin
                end
            endcase
        end else if (cfg.wr_en && cfg.index == CFG_START) begin
            current_sel_next   = at_least_one(cfg.wdata[ID_W-1:0]);
            pending_valid_next = 1'b0;
            pending_sel_next   = '0;
            pending_cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            confirm_reg       <= CONFIRM_RST;
            margin_reg        <= MARGIN_RST;
            current_sel_reg   <= at_least_one(START_RST);
            pending_sel_reg   <= '0;
            pending_valid_reg <= 1'b0;
            pending_cnt_reg   <= '0;
            best_sel_reg      <= '0;
            best_dist_reg     <= DIST_INF;
            round_open_reg    <= 1'b0;
            cur_dist_reg      <= DIST_INF;
            cur_found_reg     <= 1'b0;
        end else begin
            if (cfg.wr_en && cfg.index == CFG_CONFIRM) begin
                confirm_reg <= cfg.wdata[CNT_W-1:0];
            end
            if (cfg.wr_en && cfg.index == CFG_MARGIN) begin
                margin_reg <= cfg.wdata[MARGIN_W-1:0];
            end
            current_sel_reg   <= current_sel_next;
            pending_sel_reg   <= pending_sel_next;
            pending_valid_reg <= pending_valid_next;
            pending_cnt_reg   <= pending_cnt_next;
            best_sel_reg      <= best_sel_next;
            best_dist_reg     <= best_dist_next;
            round_open_reg    <= round_open_next;
            cur_dist_reg      <= cur_dist_next;
            cur_found_reg     <= cur_found_next;
        end
    end

    assign res.selected_id   = current_sel_next;
    assign res.pending_count = pending_cnt_next;

endmodule

/* sv/dncs_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dncs_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module dncs_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  dncs_pkg::result_t res,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output dncs_pkg::result_t m_res
);
    import dncs_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // slot frees up when empty or being drained this cycle
    assign out_free   = !valid_reg || m_ready;
    assign valid_next = res_valid ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

/* sv/debounced_nearest_candidate_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_nearest_candidate_select
// Picks the nearest candidate of each round and switches the selection only
// after the same challenger has won a configured number of rounds in a row.
//
// Usage: candidates enter on the s_ channel (valid/ready), one per item, a
// round ending at the item with s_last set. An empty-round or manual item
// also gives a result. Each round end yields one m_ item carrying the
// selection and the pending confirmation count; other items give none.
// From input acceptance, an item sits in the input register while the
// decision logic computes its result, which loads the result register
// (raising m_valid) once that register is free. Throughput is one item
// per cycle while results can enter the result register; the round state
// is updated as each item is taken, so consecutive items need no spacing.
// A stalled receiver holds the result register; the next item that has a
// result then waits in the input register and s_ready drops. Items without
// a result keep flowing. Reset (aresetn low, synchronous) empties both
// registers, sets the selection to 1 and restores the configuration
// defaults. Configuration goes through cfg_wr_en / cfg_index / cfg_wdata;
// the user must write it only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module debounced_nearest_candidate_select (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [dncs_pkg::CFGIDX_W-1:0]    cfg_index,
    input  logic [dncs_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_cmd,
    input  logic [dncs_pkg::ID_W-1:0]        s_cand_id,
    input  logic [dncs_pkg::DIST_W-1:0]      s_distance_dm,
    input  logic                             s_distance_infinite,
    input  logic                             s_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dncs_pkg::ID_W-1:0]        m_selected_id,
    output logic [dncs_pkg::CNT_W-1:0]       m_pending_count
);
    import dncs_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    item_done;
    logic    res_valid;
    logic    out_free;
    result_t res;
    result_t m_res;
    cfg_wr_t cfg;

    // gather input ports into one item
    assign s_item.cmd               = s_cmd;
    assign s_item.cand_id           = s_cand_id;
    assign s_item.distance_dm       = s_distance_dm;
    assign s_item.distance_infinite = s_distance_infinite;
    assign s_item.last              = s_last;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    dncs_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_done  (item_done)
    );

    dncs_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .item_done  (item_done),
        .res_valid  (res_valid),
        .res        (res)
    );

    dncs_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_selected_id   = m_res.selected_id;
    assign m_pending_count = m_res.pending_count;

endmodule
